// ===== src/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg: shared codes for the indexed min-heap queue
// Operation and status codes, fixed field widths and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

   localparam int HANDLE_W = 10;
   localparam int KEY_PORT_W = 32;
   localparam int COUNT_W = 11;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_DECREASE = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EMPTY       = 3'd1,
      ST_FULL        = 3'd2,
      ST_ABSENT      = 3'd3,
      ST_PRESENT     = 3'd4,
      ST_NO_DECREASE = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_DEC_RD,
      S_EXT_RD,
      S_SU_RD,
      S_SU_CMP,
      S_SD_RD,
      S_SD_L,
      S_SD_R,
      S_FIN,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/indexed_min_heap_queue.sv =====
// One transaction at a time: every sift step waits on a registered memory read.
// After reset a clearing pass marks every handle absent; no request is
// accepted during it.
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap priority queue
// Heap of (key, handle) entries in one memory, handle positions in another,
// driven by a read-modify-write sequencer that sifts with a moving hole.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue #(
   parameter int CAPACITY = 1024,
   parameter int HANDLE_COUNT = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_operation,
   input  wire logic [imhq_pkg::KEY_PORT_W-1:0]   req_key,
   input  wire logic [imhq_pkg::HANDLE_W-1:0]     req_handle,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [imhq_pkg::HANDLE_W-1:0]          rsp_out_handle,
   output logic [imhq_pkg::KEY_PORT_W-1:0]        rsp_out_key,
   output logic                                   rsp_present,
   output logic [imhq_pkg::HANDLE_W-1:0]          rsp_head_handle,
   output logic [imhq_pkg::KEY_PORT_W-1:0]        rsp_head_key,
   output logic [imhq_pkg::COUNT_W-1:0]           rsp_count
);

   localparam int CW = $clog2(CAPACITY);
   localparam int PW = $clog2(HANDLE_COUNT);
   localparam int HW = imhq_pkg::HANDLE_W;
   localparam int EW = KEY_WIDTH + HW;
   localparam int PEW = CW + 1;

   imhq_pkg::state_type state_ff, state_in;

   logic [1:0]           op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [HW-1:0]        hdl_ff, hdl_in;
   logic                 range_ff, range_in;
   logic [2:0]           status_ff, status_in;
   logic [HW-1:0]        oh_ff, oh_in;
   logic [KEY_WIDTH-1:0] ok_ff, ok_in;
   logic                 pres_ff, pres_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [KEY_WIDTH-1:0] mkey_ff, mkey_in;
   logic [HW-1:0]        mhdl_ff, mhdl_in;
   logic [KEY_WIDTH-1:0] lkey_ff, lkey_in;
   logic [HW-1:0]        lhdl_ff, lhdl_in;
   logic [CW:0]          count_ff, count_in;
   logic [KEY_WIDTH-1:0] hkey_ff, hkey_in;
   logic [HW-1:0]        hhdl_ff, hhdl_in;
   logic [PW:0]          clr_ff, clr_in;
   logic                 rv_ff, rv_in;

   logic [2:0]  r_status_ff;
   logic [9:0]  r_oh_ff, r_hh_ff;
   logic [31:0] r_ok_ff, r_hk_ff;
   logic        r_pres_ff;
   logic [10:0] r_cnt_ff;

   // memory ports
   logic           h_we;
   logic [CW-1:0]  h_wa, h_ra;
   logic [EW-1:0]  h_wd, h_rd;
   logic           p_we;
   logic [PW-1:0]  p_wa, p_ra;
   logic [PEW-1:0] p_wd, p_rd;

   imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd)
   );

   imhq_ram #(.WIDTH(PEW), .DEPTH(HANDLE_COUNT)) u_pos (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd)
   );

   // unpacked read data and derived indexes
   logic [KEY_WIDTH-1:0] rd_key;
   logic [HW-1:0]        rd_hdl;
   logic                 queued;
   logic [CW+1:0]        left_idx, right_idx;
   logic [CW-1:0]        parent_idx;
   logic                 go;

   assign rd_key     = h_rd[EW-1:HW];
   assign rd_hdl     = h_rd[HW-1:0];
   assign queued     = range_ff && p_rd[CW];
   assign left_idx   = {1'b0, cur_ff, 1'b1};
   assign right_idx  = left_idx + (CW+2)'(1);
   assign parent_idx = (cur_ff - CW'(1)) >> 1;
   assign go         = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imhq_pkg::S_CLEAR: begin
            if (clr_ff == (PW+1)'(HANDLE_COUNT - 1)) state_in = imhq_pkg::S_IDLE;
         end
         imhq_pkg::S_IDLE: begin
            if (go) state_in = imhq_pkg::S_LOOKUP;
         end
         imhq_pkg::S_LOOKUP: begin
            unique case (imhq_pkg::op_type'(op_ff))
               imhq_pkg::OP_INSERT: begin
                  if (range_ff && !queued && count_ff < (CW+1)'(CAPACITY))
                     state_in = imhq_pkg::S_SU_RD;
                  else
                     state_in = imhq_pkg::S_DONE;
               end
               imhq_pkg::OP_EXTRACT: begin
                  if (count_ff > (CW+1)'(1)) state_in = imhq_pkg::S_EXT_RD;
                  else state_in = imhq_pkg::S_DONE;
               end
               imhq_pkg::OP_DECREASE: begin
                  state_in = queued ? imhq_pkg::S_DEC_RD : imhq_pkg::S_DONE;
               end
               default: state_in = imhq_pkg::S_DONE;
            endcase
         end
         imhq_pkg::S_DEC_RD: begin
            state_in = (key_ff >= rd_key) ? imhq_pkg::S_DONE : imhq_pkg::S_SU_RD;
         end
         imhq_pkg::S_EXT_RD: state_in = imhq_pkg::S_SD_RD;
         imhq_pkg::S_SU_RD: begin
            state_in = (cur_ff == '0) ? imhq_pkg::S_FIN : imhq_pkg::S_SU_CMP;
         end
         imhq_pkg::S_SU_CMP: begin
            state_in = (rd_key <= mkey_ff) ? imhq_pkg::S_FIN : imhq_pkg::S_SU_RD;
         end
         imhq_pkg::S_SD_RD: begin
            state_in = (left_idx >= (CW+2)'(count_ff)) ? imhq_pkg::S_FIN
                                                        : imhq_pkg::S_SD_L;
         end
         imhq_pkg::S_SD_L: begin
            if (right_idx < (CW+2)'(count_ff)) state_in = imhq_pkg::S_SD_R;
            else if (rd_key < mkey_ff) state_in = imhq_pkg::S_SD_RD;
            else state_in = imhq_pkg::S_FIN;
         end
         imhq_pkg::S_SD_R: begin
            if (lkey_ff < mkey_ff || rd_key < mkey_ff) state_in = imhq_pkg::S_SD_RD;
            else state_in = imhq_pkg::S_FIN;
         end
         imhq_pkg::S_FIN: state_in = imhq_pkg::S_DONE;
         imhq_pkg::S_DONE: begin
            if (!rv_ff || rsp_ready) state_in = imhq_pkg::S_IDLE;
         end
         default: state_in = imhq_pkg::S_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      hdl_in   = hdl_ff;
      range_in = range_ff;
      status_in = status_ff;
      oh_in    = oh_ff;
      ok_in    = ok_ff;
      pres_in  = pres_ff;
      cur_in   = cur_ff;
      mkey_in  = mkey_ff;
      mhdl_in  = mhdl_ff;
      lkey_in  = lkey_ff;
      lhdl_in  = lhdl_ff;
      count_in = count_ff;
      hkey_in  = hkey_ff;
      hhdl_in  = hhdl_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff;
      req_ready = 1'b0;
      h_we = 1'b0;
      h_wa = cur_ff;
      h_wd = {mkey_ff, mhdl_ff};
      h_ra = cur_ff;
      p_we = 1'b0;
      p_wa = PW'(mhdl_ff);
      p_wd = {1'b1, cur_ff};
      p_ra = PW'(req_handle);

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         imhq_pkg::S_CLEAR: begin
            // sweep the position table, marking every handle absent
            p_we   = 1'b1;
            p_wa   = clr_ff[PW-1:0];
            p_wd   = '0;
            clr_in = clr_ff + (PW+1)'(1);
         end
         imhq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (go) begin
               op_in    = req_operation;
               key_in   = KEY_WIDTH'(req_key);
               hdl_in   = req_handle;
               range_in = 32'(req_handle) < HANDLE_COUNT;
               status_in = imhq_pkg::ST_OK;
               oh_in    = '0;
               ok_in    = '0;
            end
         end
         imhq_pkg::S_LOOKUP: begin
            pres_in = queued;
            unique case (imhq_pkg::op_type'(op_ff))
               imhq_pkg::OP_INSERT: begin
                  if (!range_ff) status_in = imhq_pkg::ST_ABSENT;
                  else if (queued) status_in = imhq_pkg::ST_PRESENT;
                  else if (count_ff >= (CW+1)'(CAPACITY)) status_in = imhq_pkg::ST_FULL;
                  else begin
                     mkey_in  = key_ff;
                     mhdl_in  = hdl_ff;
                     cur_in   = CW'(count_ff);
                     count_in = count_ff + (CW+1)'(1);
                     pres_in  = 1'b1;
                  end
               end
               imhq_pkg::OP_EXTRACT: begin
                  if (count_ff == '0) status_in = imhq_pkg::ST_EMPTY;
                  else begin
                     // hand out the root and mark its handle absent
                     oh_in    = hhdl_ff;
                     ok_in    = hkey_ff;
                     count_in = count_ff - (CW+1)'(1);
                     p_we     = 1'b1;
                     p_wa     = PW'(hhdl_ff);
                     p_wd     = '0;
                     pres_in  = queued && (hdl_ff != hhdl_ff);
                     h_ra     = CW'(count_ff - (CW+1)'(1));
                  end
               end
               imhq_pkg::OP_DECREASE: begin
                  if (!queued) status_in = imhq_pkg::ST_ABSENT;
                  else begin
                     cur_in = p_rd[CW-1:0];
                     h_ra   = p_rd[CW-1:0];
                  end
               end
               default: ;
            endcase
         end
         imhq_pkg::S_DEC_RD: begin
            if (key_ff >= rd_key) status_in = imhq_pkg::ST_NO_DECREASE;
            else begin
               mkey_in = key_ff;
               mhdl_in = hdl_ff;
            end
         end
         imhq_pkg::S_EXT_RD: begin
            // last entry becomes the moving element, hole at the root
            mkey_in = rd_key;
            mhdl_in = rd_hdl;
            cur_in  = '0;
         end
         imhq_pkg::S_SU_RD: begin
            h_ra = parent_idx;
         end
         imhq_pkg::S_SU_CMP: begin
            // parent larger: move it down into the hole
            if (rd_key > mkey_ff) begin
               h_we   = 1'b1;
               h_wa   = cur_ff;
               h_wd   = h_rd;
               p_we   = 1'b1;
               p_wa   = PW'(rd_hdl);
               p_wd   = {1'b1, cur_ff};
               cur_in = parent_idx;
            end
         end
         imhq_pkg::S_SD_RD: begin
            h_ra = CW'(left_idx);
         end
         imhq_pkg::S_SD_L: begin
            lkey_in = rd_key;
            lhdl_in = rd_hdl;
            h_ra    = CW'(right_idx);
            if (!(right_idx < (CW+2)'(count_ff)) && rd_key < mkey_ff) begin
               h_we   = 1'b1;
               h_wa   = cur_ff;
               h_wd   = h_rd;
               p_we   = 1'b1;
               p_wa   = PW'(rd_hdl);
               p_wd   = {1'b1, cur_ff};
               cur_in = CW'(left_idx);
               if (cur_ff == '0) begin
                  hkey_in = rd_key;
                  hhdl_in = rd_hdl;
               end
            end
         end
         imhq_pkg::S_SD_R: begin
            // right wins only when strictly below both left and moving keys
            if (rd_key < mkey_ff && rd_key < lkey_ff) begin
               h_we   = 1'b1;
               h_wa   = cur_ff;
               h_wd   = h_rd;
               p_we   = 1'b1;
               p_wa   = PW'(rd_hdl);
               p_wd   = {1'b1, cur_ff};
               cur_in = CW'(right_idx);
               if (cur_ff == '0) begin
                  hkey_in = rd_key;
                  hhdl_in = rd_hdl;
               end
            end else if (lkey_ff < mkey_ff) begin
               h_we   = 1'b1;
               h_wa   = cur_ff;
               h_wd   = {lkey_ff, lhdl_ff};
               p_we   = 1'b1;
               p_wa   = PW'(lhdl_ff);
               p_wd   = {1'b1, cur_ff};
               cur_in = CW'(left_idx);
               if (cur_ff == '0) begin
                  hkey_in = lkey_ff;
                  hhdl_in = lhdl_ff;
               end
            end
         end
         imhq_pkg::S_FIN: begin
            // drop the moving element into the hole
            h_we = 1'b1;
            p_we = 1'b1;
            if (cur_ff == '0) begin
               hkey_in = mkey_ff;
               hhdl_in = mhdl_ff;
            end
         end
         imhq_pkg::S_DONE: begin
            if (!rv_ff || rsp_ready) rv_in = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imhq_pkg::S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      hdl_ff   <= hdl_in;
      range_ff <= range_in;
      status_ff <= status_in;
      oh_ff    <= oh_in;
      ok_ff    <= ok_in;
      pres_ff  <= pres_in;
      cur_ff   <= cur_in;
      mkey_ff  <= mkey_in;
      mhdl_ff  <= mhdl_in;
      lkey_ff  <= lkey_in;
      lhdl_ff  <= lhdl_in;
      hkey_ff  <= hkey_in;
      hhdl_ff  <= hhdl_in;
   end

   // load the response register when the transaction completes
   always_ff @(posedge clock) begin
      if (state_ff == imhq_pkg::S_DONE && (!rv_ff || rsp_ready)) begin
         r_status_ff <= status_ff;
         r_oh_ff     <= oh_ff;
         r_ok_ff     <= 32'(ok_ff);
         r_pres_ff   <= pres_ff;
         r_hh_ff     <= (count_ff == '0) ? '0 : hhdl_ff;
         r_hk_ff     <= (count_ff == '0) ? '0 : 32'(hkey_ff);
         r_cnt_ff    <= 11'(count_ff);
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = r_status_ff;
   assign rsp_out_handle  = r_oh_ff;
   assign rsp_out_key     = r_ok_ff;
   assign rsp_present     = r_pres_ff;
   assign rsp_head_handle = r_hh_ff;
   assign rsp_head_key    = r_hk_ff;
   assign rsp_count       = r_cnt_ff;

   // checks
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CW+1)'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_lookup : assert property (@(posedge clock) disable iff (reset)
      go |=> state_ff == imhq_pkg::S_LOOKUP)
      else $error("accepted transaction did not start lookup");

   a_empty_head : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_head_key == '0 && rsp_head_handle == '0)
      else $error("empty queue reports a head");

   a_clear_block : assert property (@(posedge clock) disable iff (reset)
      state_ff == imhq_pkg::S_CLEAR |-> !req_ready)
      else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

// ===== src/imhq_ram.sv =====
// ----------------------------------------------------------------------------
// imhq_ram: simple dual-port synchronous memory
// One write and one read a cycle, read data registered and valid the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== tb/tb_indexed_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue: self-checking bench for the indexed min-heap queue
// Drives insert, extract, decrease and contains transactions through phases of
// idling and back-pressure, mirrors the heap in a local model and compares
// every response field against the model's prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_indexed_min_heap_queue;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 1024;
   localparam int NHANDLE = 1024;

   typedef struct packed {
      imhq_pkg::op_type op;
      logic [31:0]      key;
      logic [9:0]       handle;
   } heap_req_type;

   typedef struct packed {
      imhq_pkg::status_type status;
      logic [9:0]           out_handle;
      logic [31:0]          out_key;
      logic                 present;
      logic [9:0]           head_handle;
      logic [31:0]          head_key;
      logic [10:0]          count;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [31:0] req_key = '0;
   logic [9:0]  req_handle = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [9:0]  rsp_out_handle;
   logic [31:0] rsp_out_key;
   logic        rsp_present;
   logic [9:0]  rsp_head_handle;
   logic [31:0] rsp_head_key;
   logic [10:0] rsp_count;

   indexed_min_heap_queue u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_key(req_key), .req_handle(req_handle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_out_handle(rsp_out_handle),
      .rsp_out_key(rsp_out_key), .rsp_present(rsp_present),
      .rsp_head_handle(rsp_head_handle), .rsp_head_key(rsp_head_key),
      .rsp_count(rsp_count)
   );

   // Model of the heap
   logic [31:0] mdl_keys [CAP];
   logic [9:0]  mdl_handles [CAP];
   int          mdl_pos [NHANDLE];
   bit          mdl_queued [NHANDLE];
   int          mdl_count;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void heap_place(int p, logic [31:0] k, logic [9:0] h);
      mdl_keys[p] = k;
      mdl_handles[p] = h;
      mdl_pos[h] = p;
   endfunction

   function automatic void heap_swap(int a, int b);
      logic [31:0] ka;
      logic [9:0]  ha;
      ka = mdl_keys[a];
      ha = mdl_handles[a];
      heap_place(a, mdl_keys[b], mdl_handles[b]);
      heap_place(b, ka, ha);
   endfunction

   function automatic void heap_sift_up(int p);
      int up;
      while (p > 0) begin
         up = (p - 1) / 2;
         if (mdl_keys[up] <= mdl_keys[p]) break;
         heap_swap(up, p);
         p = up;
      end
   endfunction

   function automatic void heap_sift_down(int p);
      int best;
      int l;
      int r;
      forever begin
         best = p;
         l = 2 * p + 1;
         r = 2 * p + 2;
         if (l < mdl_count && mdl_keys[l] < mdl_keys[best]) best = l;
         if (r < mdl_count && mdl_keys[r] < mdl_keys[best]) best = r;
         if (best == p) break;
         heap_swap(p, best);
         p = best;
      end
   endfunction

   // Apply one transaction to the model and return the response it implies
   function automatic heap_rsp_type heap_apply(heap_req_type rq);
      heap_rsp_type rs;
      int p;
      rs = '0;
      rs.status = imhq_pkg::ST_OK;
      case (rq.op)
         imhq_pkg::OP_INSERT: begin
            if (mdl_queued[rq.handle]) rs.status = imhq_pkg::ST_PRESENT;
            else if (mdl_count >= CAP) rs.status = imhq_pkg::ST_FULL;
            else begin
               heap_place(mdl_count, rq.key, rq.handle);
               mdl_queued[rq.handle] = 1'b1;
               mdl_count++;
               heap_sift_up(mdl_count - 1);
            end
         end
         imhq_pkg::OP_EXTRACT: begin
            if (mdl_count == 0) rs.status = imhq_pkg::ST_EMPTY;
            else begin
               rs.out_key = mdl_keys[0];
               rs.out_handle = mdl_handles[0];
               mdl_queued[mdl_handles[0]] = 1'b0;
               mdl_count--;
               if (mdl_count > 0) begin
                  heap_place(0, mdl_keys[mdl_count], mdl_handles[mdl_count]);
                  heap_sift_down(0);
               end
            end
         end
         imhq_pkg::OP_DECREASE: begin
            if (!mdl_queued[rq.handle]) rs.status = imhq_pkg::ST_ABSENT;
            else begin
               p = mdl_pos[rq.handle];
               if (rq.key >= mdl_keys[p]) rs.status = imhq_pkg::ST_NO_DECREASE;
               else begin
                  mdl_keys[p] = rq.key;
                  heap_sift_up(p);
               end
            end
         end
         default: ;
      endcase
      rs.present = mdl_queued[rq.handle];
      rs.head_handle = (mdl_count != 0) ? mdl_handles[0] : '0;
      rs.head_key = (mdl_count != 0) ? mdl_keys[0] : '0;
      rs.count = 11'(mdl_count);
      return rs;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Driver: hold the payload until accepted, insert random gaps
   always @(posedge clock) begin
      heap_req_type nx;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps.push_back(heap_apply(heap_req_type'({req_operation,
                                                    req_key, req_handle})));
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nx = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_operation <= nx.op;
            req_key <= nx.key;
            req_handle <= nx.handle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each response against the oldest prediction
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 32'd0, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_out_handle != want.out_handle)
                  report_mismatch("out_handle", 32'(rsp_out_handle),
                                  32'(want.out_handle));
               if (rsp_out_key != want.out_key)
                  report_mismatch("out_key", rsp_out_key, want.out_key);
               if (rsp_present != want.present)
                  report_mismatch("present", 32'(rsp_present), 32'(want.present));
               if (rsp_head_handle != want.head_handle)
                  report_mismatch("head_handle", 32'(rsp_head_handle),
                                  32'(want.head_handle));
               if (rsp_head_key != want.head_key)
                  report_mismatch("head_key", rsp_head_key, want.head_key);
               if (rsp_count != want.count)
                  report_mismatch("count", 32'(rsp_count), 32'(want.count));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic heap_req_type mk_req(imhq_pkg::op_type op, logic [31:0] k,
                                           logic [9:0] h);
      heap_req_type r;
      r.op = op;
      r.key = k;
      r.handle = h;
      return r;
   endfunction

   // Key with random magnitude so small keys, ties and extremes all occur
   function automatic logic [31:0] rand_key();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom_range(1000);
      endcase
   endfunction

   // Stimulus: directed corner cases then random phases
   initial begin
      int phase;
      int n;
      for (int i = 0; i < NHANDLE; i++) mdl_queued[i] = 1'b0;
      mdl_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty extract, extremes, duplicate, absent, no-decrease
      pending_reqs.push_back(mk_req(imhq_pkg::OP_EXTRACT, 32'd0, 10'd0));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_CONTAINS, 32'd0, 10'h3FF));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, 32'd5, 10'h3FF));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, 32'hFFFF_FFFF, 10'h3FF));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, 32'd0, 10'd0));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, 32'd7, 10'd0));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, 32'd100, 10'h155));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, 32'd100, 10'h2AA));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, 32'd100, 10'h155));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, 32'd200, 10'h155));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, 32'd0, 10'h3FF));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, 32'd5, 10'h2AA));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_CONTAINS, 32'd0, 10'h155));
      pending_reqs.push_back(mk_req(imhq_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 10'h100));
      for (int i = 0; i < 6; i++)
         pending_reqs.push_back(mk_req(imhq_pkg::OP_EXTRACT, 32'd0, 10'd0));

      // Random phases: none, sender idle, receiver stall, both
      for (phase = 0; phase < 4; phase++) begin
         wait (pending_reqs.size() == 0);
         send_idle_pct = (phase == 1 || phase == 3) ? 53 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? 53 : 0;
         if (phase == 3) begin
            send_idle_pct = 11;
            recv_stall_pct = 11;
         end
         for (n = 0; n < 220; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: pending_reqs.push_back(mk_req(imhq_pkg::OP_INSERT, rand_key(),
                                         10'($urandom_range(phase == 0 ? 63 : 1023))));
               4, 5: pending_reqs.push_back(mk_req(imhq_pkg::OP_EXTRACT, $urandom,
                                                   10'($urandom)));
               6, 7: pending_reqs.push_back(mk_req(imhq_pkg::OP_DECREASE, rand_key(),
                                         10'($urandom_range(phase == 0 ? 63 : 1023))));
               default: pending_reqs.push_back(mk_req(imhq_pkg::OP_CONTAINS, $urandom,
                                                      10'($urandom)));
            endcase
         end
      end

      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("tb_indexed_min_heap_queue: done, clean");
      end else begin
         $display("tb_indexed_min_heap_queue: done, errors");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #(20_000_000);
      $display("tb_indexed_min_heap_queue: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
